>>> rtl/core/acc_pkg.sv
// Shared constants, types and arithmetic helpers for the affine chain composer.
package acc_pkg;

  localparam int DATA_W        = 32;
  localparam int FRACTION_BITS = 16;
  localparam int MATRIX_ELEMS  = 16;
  localparam int DIM_MAX       = 4;
  localparam int DIM_MIN       = 3;
  localparam int ROW_W         = 2;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int RND_W         = PROD_W - FRACTION_BITS;
  localparam int SUM_W         = RND_W + 3;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 1;

  localparam bit HAS_3D = (MATRIX_ELEMS >= 16);

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [ROW_W-1:0] row_idx_t;

  localparam word_t ONE = word_t'(1 << FRACTION_BITS);

  localparam row_idx_t ROW_LAST_3D = row_idx_t'(DIM_MAX - 1);
  localparam row_idx_t ROW_LAST_2D = row_idx_t'(DIM_MIN - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_MODE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_ORDER = CFG_IDX_W'(1);

  localparam logic MAT_PRODUCT = 1'b0;
  localparam logic MAT_DERIV   = 1'b1;

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRACTION_BITS - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

  typedef struct packed {
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] d;
    logic              p_sat;
    logic              d_sat;
  } lane_res_t;

  typedef struct packed {
    logic [DATA_W-1:0] v;
    logic              sat;
  } sat_t;

  typedef struct packed {
    logic load;
    logic flag;
    logic dim4;
    logic order;
  } emit_ctl_t;

  // Rounds a full product to the fraction width: add half an LSB, then floor.
  function automatic logic signed [RND_W-1:0] round_prod(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + RND_HALF;
    return t[PROD_W-1:FRACTION_BITS];
  endfunction

  function automatic sat_t sat_word(input logic signed [SUM_W-1:0] s);
    sat_t r;
    if (s > SAT_HI) begin
      r.v   = SAT_HI[DATA_W-1:0];
      r.sat = 1'b1;
    end else if (s < SAT_LO) begin
      r.v   = SAT_LO[DATA_W-1:0];
      r.sat = 1'b1;
    end else begin
      r.v   = s[DATA_W-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/acc_in_if.sv
// Input channel carrying one row of a transform and of its time derivative.
interface acc_in_if;
  logic                 valid;
  logic                 ready;
  acc_pkg::row_idx_t    row_index;
  acc_pkg::word_t       mat_c0;
  acc_pkg::word_t       mat_c1;
  acc_pkg::word_t       mat_c2;
  acc_pkg::word_t       mat_c3;
  acc_pkg::word_t       rate_c0;
  acc_pkg::word_t       rate_c1;
  acc_pkg::word_t       rate_c2;
  acc_pkg::word_t       rate_c3;
  logic                 final_transform;

  modport source (
    output valid, row_index, mat_c0, mat_c1, mat_c2, mat_c3,
           rate_c0, rate_c1, rate_c2, rate_c3, final_transform,
    input  ready
  );
  modport sink (
    input  valid, row_index, mat_c0, mat_c1, mat_c2, mat_c3,
           rate_c0, rate_c1, rate_c2, rate_c3, final_transform,
    output ready
  );
endinterface

>>> rtl/core/acc_out_if.sv
// Result channel carrying one row of the composed product or its derivative.
interface acc_out_if;
  logic                 valid;
  logic                 ready;
  logic                 which_matrix;
  acc_pkg::row_idx_t    out_row;
  acc_pkg::word_t       out_c0;
  acc_pkg::word_t       out_c1;
  acc_pkg::word_t       out_c2;
  acc_pkg::word_t       out_c3;
  logic                 overflow_seen;
  logic                 last_row;

  modport source (
    output valid, which_matrix, out_row, out_c0, out_c1, out_c2, out_c3,
           overflow_seen, last_row,
    input  ready
  );
  modport sink (
    input  valid, which_matrix, out_row, out_c0, out_c1, out_c2, out_c3,
           overflow_seen, last_row,
    output ready
  );
endinterface

>>> rtl/core/affine_chain_compose_with_rate_unit.sv
// Top level of the affine chain composer with first time derivative.
// Each input item carries one row of a transform B and of its rate Bdot; four
// column lanes form that row of B*P and B*D + Bdot*P: a registered multiply
// stage (twelve 32x32 products per lane), then rounding, summing and
// saturation as the row is written. Rows of one transform are taken one per
// cycle, but after the last row of a transform the input waits while the new
// product commits. On the final transform the product (and the derivative
// when derivative_order is 1) moves into an output buffer and leaves as 3, 4,
// 6 or 8 result items, the first once the final row has passed the multiply
// stage into that buffer; input keeps flowing meanwhile, and only the final
// row of the next chain waits in the multiply stage until that buffer has
// drained. A configuration write restarts the chain.
module affine_chain_compose_with_rate_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [acc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [acc_pkg::CFG_DATA_W-1:0]      cfg_data,
  acc_in_if.sink                              in_ch,
  acc_out_if.source                           out_ch
);

  logic dim_r;
  logic order_r;
  logic dim4;
  acc_pkg::row_idx_t row_last;

  acc_pkg::word_t cur_p_r   [acc_pkg::DIM_MAX][acc_pkg::DIM_MAX];
  acc_pkg::word_t cur_d_r   [acc_pkg::DIM_MAX][acc_pkg::DIM_MAX];
  acc_pkg::word_t stage_p_r [acc_pkg::DIM_MAX][acc_pkg::DIM_MAX];
  acc_pkg::word_t stage_d_r [acc_pkg::DIM_MAX][acc_pkg::DIM_MAX];
  acc_pkg::word_t commit_p  [acc_pkg::DIM_MAX][acc_pkg::DIM_MAX];
  acc_pkg::word_t commit_d  [acc_pkg::DIM_MAX][acc_pkg::DIM_MAX];
  logic           flag_r;
  logic           flag_upd;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  acc_pkg::row_idx_t s1_row_r;
  logic              s1_last_r;
  logic              s1_final_r;
  logic              s1_fire;
  logic              in_acc;
  logic              row_ok;
  logic              emit_busy;

  acc_pkg::word_t     b    [acc_pkg::DIM_MAX];
  acc_pkg::word_t     bd   [acc_pkg::DIM_MAX];
  acc_pkg::word_t     pcol [acc_pkg::DIM_MAX][acc_pkg::DIM_MAX];
  acc_pkg::word_t     dcol [acc_pkg::DIM_MAX][acc_pkg::DIM_MAX];
  acc_pkg::lane_res_t lane_res [acc_pkg::DIM_MAX];
  logic               p_sat_any;
  logic               d_sat_any;
  acc_pkg::emit_ctl_t emit_ctl;

  assign dim4     = dim_r & acc_pkg::HAS_3D;
  assign row_last = dim4 ? acc_pkg::ROW_LAST_3D : acc_pkg::ROW_LAST_2D;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r   <= 1'b1;
      order_r <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == acc_pkg::CFG_DIM_MODE) begin
        dim_r <= cfg_data[0];
      end
      if (cfg_index == acc_pkg::CFG_DERIV_ORDER) begin
        order_r <= cfg_data[0];
      end
    end
  end

  // Input side and the multiply stage handshake.
  assign row_ok      = (in_ch.row_index <= row_last);
  assign s1_fire     = s1_valid_r && !(s1_final_r && emit_busy);
  assign in_ch.ready = !s1_valid_r || (s1_fire && !s1_last_r);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = row_ok;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_row_r   <= in_ch.row_index;
      s1_last_r  <= (in_ch.row_index == row_last);
      s1_final_r <= (in_ch.row_index == row_last) && in_ch.final_transform;
    end
  end

  always_comb begin
    b[0]  = in_ch.mat_c0;
    b[1]  = in_ch.mat_c1;
    b[2]  = in_ch.mat_c2;
    b[3]  = dim4 ? in_ch.mat_c3 : '0;
    bd[0] = in_ch.rate_c0;
    bd[1] = in_ch.rate_c1;
    bd[2] = in_ch.rate_c2;
    bd[3] = dim4 ? in_ch.rate_c3 : '0;
    for (int c = 0; c < acc_pkg::DIM_MAX; c++) begin
      for (int k = 0; k < acc_pkg::DIM_MAX; k++) begin
        pcol[c][k] = cur_p_r[k][c];
        dcol[c][k] = cur_d_r[k][c];
      end
    end
  end

  for (genvar c = 0; c < acc_pkg::DIM_MAX; c++) begin : g_lane
    acc_lane u_lane (
      .clk     (clk),
      .load_i  (in_acc && row_ok),
      .b_i     (b),
      .bd_i    (bd),
      .p_col_i (pcol[c]),
      .d_col_i (dcol[c]),
      .res_o   (lane_res[c])
    );
  end

  // Merge the lane results into the row being written and the committed matrices.
  always_comb begin
    p_sat_any = 1'b0;
    d_sat_any = 1'b0;
    for (int c = 0; c < acc_pkg::DIM_MAX; c++) begin
      if (c < acc_pkg::DIM_MIN || dim4) begin
        p_sat_any = p_sat_any | lane_res[c].p_sat;
        d_sat_any = d_sat_any | lane_res[c].d_sat;
      end
    end
    flag_upd = flag_r | p_sat_any | (order_r & d_sat_any);
    for (int k = 0; k < acc_pkg::DIM_MAX; k++) begin
      for (int c = 0; c < acc_pkg::DIM_MAX; c++) begin
        if (acc_pkg::ROW_W'(k) == s1_row_r) begin
          commit_p[k][c] = acc_pkg::word_t'(lane_res[c].p);
          commit_d[k][c] = acc_pkg::word_t'(lane_res[c].d);
        end else begin
          commit_p[k][c] = stage_p_r[k][c];
          commit_d[k][c] = stage_d_r[k][c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      for (int c = 0; c < acc_pkg::DIM_MAX; c++) begin
        stage_p_r[s1_row_r][c] <= acc_pkg::word_t'(lane_res[c].p);
        stage_d_r[s1_row_r][c] <= acc_pkg::word_t'(lane_res[c].d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we || (s1_fire && s1_final_r)) begin
      for (int k = 0; k < acc_pkg::DIM_MAX; k++) begin
        for (int c = 0; c < acc_pkg::DIM_MAX; c++) begin
          cur_p_r[k][c] <= (k == c) ? acc_pkg::ONE : '0;
          cur_d_r[k][c] <= '0;
        end
      end
      flag_r <= 1'b0;
    end else if (s1_fire) begin
      flag_r <= flag_upd;
      if (s1_last_r) begin
        cur_p_r <= commit_p;
        cur_d_r <= commit_d;
      end
    end
  end

  assign emit_ctl.load  = s1_fire && s1_final_r;
  assign emit_ctl.flag  = flag_upd;
  assign emit_ctl.dim4  = dim4;
  assign emit_ctl.order = order_r;

  acc_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (emit_ctl),
    .p_i    (commit_p),
    .d_i    (commit_d),
    .busy_o (emit_busy),
    .out_ch (out_ch)
  );

endmodule

>>> rtl/core/acc_lane.sv
// One column lane: registered products, then rounding, summing and saturation.
module acc_lane (
  input  logic               clk,
  input  logic               load_i,
  input  acc_pkg::word_t     b_i     [acc_pkg::DIM_MAX],
  input  acc_pkg::word_t     bd_i    [acc_pkg::DIM_MAX],
  input  acc_pkg::word_t     p_col_i [acc_pkg::DIM_MAX],
  input  acc_pkg::word_t     d_col_i [acc_pkg::DIM_MAX],
  output acc_pkg::lane_res_t res_o
);

  logic signed [acc_pkg::PROD_W-1:0] bp_r [acc_pkg::DIM_MAX];
  logic signed [acc_pkg::PROD_W-1:0] bdd_r [acc_pkg::DIM_MAX];
  logic signed [acc_pkg::PROD_W-1:0] rp_r [acc_pkg::DIM_MAX];

  always_ff @(posedge clk) begin
    if (load_i) begin
      for (int k = 0; k < acc_pkg::DIM_MAX; k++) begin
        bp_r[k]  <= acc_pkg::PROD_W'(b_i[k]) * acc_pkg::PROD_W'(p_col_i[k]);
        bdd_r[k] <= acc_pkg::PROD_W'(b_i[k]) * acc_pkg::PROD_W'(d_col_i[k]);
        rp_r[k]  <= acc_pkg::PROD_W'(bd_i[k]) * acc_pkg::PROD_W'(p_col_i[k]);
      end
    end
  end

  logic signed [acc_pkg::SUM_W-1:0] sum_p;
  logic signed [acc_pkg::SUM_W-1:0] sum_d;
  acc_pkg::sat_t                    sat_p;
  acc_pkg::sat_t                    sat_d;

  always_comb begin
    sum_p = '0;
    sum_d = '0;
    for (int k = 0; k < acc_pkg::DIM_MAX; k++) begin
      sum_p = sum_p + acc_pkg::SUM_W'(acc_pkg::round_prod(bp_r[k]));
      sum_d = sum_d + acc_pkg::SUM_W'(acc_pkg::round_prod(bdd_r[k]))
                    + acc_pkg::SUM_W'(acc_pkg::round_prod(rp_r[k]));
    end
    sat_p       = acc_pkg::sat_word(sum_p);
    sat_d       = acc_pkg::sat_word(sum_d);
    res_o.p     = sat_p.v;
    res_o.d     = sat_d.v;
    res_o.p_sat = sat_p.sat;
    res_o.d_sat = sat_d.sat;
  end

endmodule

>>> rtl/core/acc_emit.sv
// Output buffer that holds a finished chain and sends it out one row per item.
module acc_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  acc_pkg::emit_ctl_t ctl_i,
  input  acc_pkg::word_t     p_i [acc_pkg::DIM_MAX][acc_pkg::DIM_MAX],
  input  acc_pkg::word_t     d_i [acc_pkg::DIM_MAX][acc_pkg::DIM_MAX],
  output logic               busy_o,
  acc_out_if.source          out_ch
);

  acc_pkg::word_t    buf_r [2][acc_pkg::DIM_MAX][acc_pkg::DIM_MAX];
  logic              flag_r;
  logic              dim4_r;
  logic              order_r;
  logic              valid_r;
  logic              valid_nxt;
  logic              sel_r;
  logic              sel_nxt;
  acc_pkg::row_idx_t row_r;
  acc_pkg::row_idx_t row_nxt;
  acc_pkg::row_idx_t row_last;
  logic              is_last;
  logic              out_acc;

  always_ff @(posedge clk) begin
    if (ctl_i.load) begin
      buf_r[acc_pkg::MAT_PRODUCT] <= p_i;
      buf_r[acc_pkg::MAT_DERIV]   <= d_i;
      flag_r  <= ctl_i.flag;
      dim4_r  <= ctl_i.dim4;
      order_r <= ctl_i.order;
    end
  end

  assign row_last = dim4_r ? acc_pkg::ROW_LAST_3D : acc_pkg::ROW_LAST_2D;
  assign is_last  = (row_r == row_last) && (sel_r == order_r);
  assign out_acc  = valid_r && out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    sel_nxt   = sel_r;
    row_nxt   = row_r;
    if (ctl_i.load) begin
      valid_nxt = 1'b1;
      sel_nxt   = acc_pkg::MAT_PRODUCT;
      row_nxt   = '0;
    end else if (out_acc) begin
      if (is_last) begin
        valid_nxt = 1'b0;
      end else if (row_r == row_last) begin
        row_nxt = '0;
        sel_nxt = acc_pkg::MAT_DERIV;
      end else begin
        row_nxt = row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= acc_pkg::MAT_PRODUCT;
      row_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
      row_r   <= row_nxt;
    end
  end

  assign busy_o              = valid_r;
  assign out_ch.valid        = valid_r;
  assign out_ch.which_matrix = sel_r;
  assign out_ch.out_row      = row_r;
  assign out_ch.out_c0       = buf_r[sel_r][row_r][0];
  assign out_ch.out_c1       = buf_r[sel_r][row_r][1];
  assign out_ch.out_c2       = buf_r[sel_r][row_r][2];
  assign out_ch.out_c3       = dim4_r ? buf_r[sel_r][row_r][3] : '0;
  assign out_ch.overflow_seen = flag_r;
  assign out_ch.last_row     = is_last;

endmodule
